FILE: rtl/core/dba_pkg.sv
// ----------------------------------------------------------------------------
// dba_pkg
// Constants, command codes and bit helpers for the dual bitmap allocator.
// ----------------------------------------------------------------------------
package dba_pkg;

    localparam int MAP_BYTES_DEF = 512;
    localparam int REACH_BYTES   = 512;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BYTE_MSB  = 8'h80;

    // Position of the first zero bit, MSB first; zero for a full byte.
    function automatic logic [2:0] first_zero_bit(input logic [7:0] value);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i <= 7; i++)
        begin
            if (!value[i])
            begin
                pos = 3'(7 - i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/core/dual_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// dual_bitmap_allocator_unit
// Steps: a set or clear reads the byte, writes it back and loads the result
// (an index beyond the map or an unused code goes straight to the result);
// a find scans up to min(MAP_BYTES, 512) bytes, one memory read per scanned byte.
// Requests: one request in work; the next is taken the cycle after the
// result is loaded, and a result waits while the output is held.
// Reset: both bitmaps are zeroed first by a pass over min(MAP_BYTES, 512) bytes.
// ----------------------------------------------------------------------------
module dual_bitmap_allocator_unit #(
    parameter int MAP_BYTES = dba_pkg::MAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        map_select,
    input  logic [11:0] bit_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] free_index,
    output logic        map_full
);

    localparam int SCAN_BYTES = (MAP_BYTES < dba_pkg::REACH_BYTES) ?
                                MAP_BYTES : dba_pkg::REACH_BYTES;
    localparam int AW = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SCAN_BYTES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODIFY = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [7:0] inode_mem [SCAN_BYTES];
    logic [7:0] block_mem [SCAN_BYTES];
    logic [7:0] inode_q;
    logic [7:0] block_q;
    logic [7:0] map_q;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;
    logic          sel_reg, sel_next;
    logic          is_set_reg, is_set_next;
    logic [7:0]    mask_reg, mask_next;
    logic [11:0]   res_index_reg, res_index_next;
    logic          res_full_reg, res_full_next;
    logic [11:0]   free_index_reg;
    logic          map_full_reg;
    logic          load_out;

    logic          we_inode, we_block;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [8:0]    byte_num;

    assign byte_num = bit_index[11:3];
    assign map_q    = sel_reg ? block_q : inode_q;
    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (we_inode)
        begin
            inode_mem[wr_addr] <= wr_data;
        end
        if (we_block)
        begin
            block_mem[wr_addr] <= wr_data;
        end
        inode_q <= inode_mem[addr_next];
        block_q <= block_mem[addr_next];
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        sel_next       = sel_reg;
        is_set_next    = is_set_reg;
        mask_next      = mask_reg;
        res_index_next = res_index_reg;
        res_full_next  = res_full_reg;
        load_out       = 1'b0;
        we_inode       = 1'b0;
        we_block       = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = map_q;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we_inode = 1'b1;
                we_block = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = 8'h00;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sel_next       = map_select;
                    is_set_next    = (command == dba_pkg::CMD_SET);
                    mask_next      = dba_pkg::BYTE_MSB >> bit_index[2:0];
                    res_index_next = 12'd0;
                    res_full_next  = 1'b0;
                    unique case (command) inside
                        dba_pkg::CMD_SET, dba_pkg::CMD_CLEAR:
                        begin
                            if ({1'b0, byte_num} < 10'(SCAN_BYTES))
                            begin
                                addr_next  = byte_num[AW-1:0];
                                state_next = ST_MODIFY;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        dba_pkg::CMD_FIND:
                        begin
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                we_inode   = !sel_reg;
                we_block   = sel_reg;
                wr_data    = is_set_reg ? (map_q | mask_reg) : (map_q & ~mask_reg);
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (map_q != dba_pkg::BYTE_FULL)
                begin
                    res_index_next = 12'({addr_reg, dba_pkg::first_zero_bit(map_q)});
                    state_next     = ST_FINISH;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    res_full_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        is_set_reg    <= is_set_next;
        mask_reg      <= mask_next;
        res_index_reg <= res_index_next;
        res_full_reg  <= res_full_next;
        if (load_out)
        begin
            free_index_reg <= res_index_reg;
            map_full_reg   <= res_full_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign free_index = free_index_reg;
    assign map_full   = map_full_reg;

`ifndef NO_ASSERTIONS
    // one request in work at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in work");

    // no request during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request taken during map clearing");

    // a full map reports index zero
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && map_full) |-> (free_index == 12'd0))
        else $error("full map with non-zero index");

    // a loaded result is shown in the following cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("result lost on output load");
`endif

endmodule
